@@ src/smx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, sizes and codes of the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int VAR_ENTRIES = 64;

  localparam int WORD_W  = 32;
  localparam int OP_W    = 5;
  localparam int FAULT_W = 3;
  localparam int DEPTH_W = 6;
  localparam int SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int VC_W    = $clog2(VAR_ENTRIES + 1);
  localparam int VAR_AW  = (VAR_ENTRIES > 1) ? $clog2(VAR_ENTRIES) : 1;
  localparam int STEP_W  = $clog2(WORD_W);

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [OP_W-1:0] {
    OP_POP     = 5'd0,
    OP_NEG     = 5'd1,
    OP_POW     = 5'd2,
    OP_MUL     = 5'd3,
    OP_DIV     = 5'd4,
    OP_ADD     = 5'd5,
    OP_SUB     = 5'd6,
    OP_LT      = 5'd7,
    OP_GT      = 5'd8,
    OP_LE      = 5'd9,
    OP_GE      = 5'd10,
    OP_NE      = 5'd11,
    OP_EQ      = 5'd12,
    OP_AND     = 5'd13,
    OP_OR      = 5'd14,
    OP_ASSIGN  = 5'd15,
    OP_JMP     = 5'd16,
    OP_BRZ     = 5'd17,
    OP_PUSHIMM = 5'd18,
    OP_PUSHVAR = 5'd19
  } op_t;

  typedef enum logic [FAULT_W-1:0] {
    FLT_OK         = 3'd0,
    FLT_UNDERFLOW  = 3'd1,
    FLT_OVERFLOW   = 3'd2,
    FLT_MISSING    = 3'd3,
    FLT_STORE_FULL = 3'd4,
    FLT_DIV_ZERO   = 3'd5
  } fault_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_EXEC,
    S_MUL,
    S_FIN_ACC,
    S_POW_A,
    S_POW_B,
    S_DIV,
    S_FIN_DIV,
    S_SCAN_RD,
    S_SCAN_CMP
  } state_t;

  // How the stack changes when an instruction completes.
  typedef enum logic [2:0] {
    C_NONE,
    C_POP,
    C_REPL1,
    C_REPL2,
    C_PUSH
  } commit_t;

  typedef enum logic [2:0] {
    RS_ALU,
    RS_ACC,
    RS_DIV,
    RS_TOP,
    RS_NEGTOP,
    RS_OPND,
    RS_VAR
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     cap_a;
    logic     mul_init;
    logic     pow_init;
    logic     mul_acc;
    logic     mul_base;
    logic     div_init;
    logic     div_step;
    logic     scan_init;
    logic     idx_inc;
    logic     val_wr;
    logic     new_var;
    logic     done;
    fault_t   fault;
    logic     jump;
    commit_t  commit;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            out_free;
    logic            cnt_lt2;
    logic            cnt_zero;
    logic            cnt_full;
    logic            top_zero;
    logic            exp_zero;
    logic            exp_lsb;
    logic            div_last;
    logic            vcnt_zero;
    logic            vfull;
    logic            key_hit;
    logic            scan_last;
  } sts_t;

endpackage
`default_nettype wire

@@ src/smx_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ src/smx_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_dp
// Datapath: stack and variable memories, ALU, shared multiplier, divider
// and the output register.
// ----------------------------------------------------------------------------
module smx_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [smx_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [smx_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire smx_pkg::cmd_t                   cmd,
  output smx_pkg::sts_t                        sts,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [smx_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int W = smx_pkg::WORD_W;

  logic [smx_pkg::OP_W-1:0]   op_r;
  logic [W-1:0]               opnd_r, a_r, top_r, top_nxt;
  logic [smx_pkg::SP_W-1:0]   cnt_r, cnt_nxt;
  logic [smx_pkg::VC_W-1:0]   vcnt_r;
  logic [smx_pkg::VAR_AW-1:0] idx_r;
  logic [W-1:0]               acc_r, base_r, exp_r;
  logic [W-1:0]               rem_r, quot_r, dvs_r;
  logic                       qneg_r;
  logic [smx_pkg::STEP_W-1:0] step_r;

  logic                       out_valid_r;
  logic [smx_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [W-1:0] stk_rdata, key_rdata, val_rdata;
  logic         stk_we;
  logic [smx_pkg::STK_AW-1:0] stk_waddr, stk_raddr;
  logic [W-1:0] res, alu_res, div_res, key, mul_x, prod;
  logic [W:0]   rem_sh, diff;
  logic [W-1:0] abs_a, abs_b;
  logic         val_we;
  logic [smx_pkg::VAR_AW-1:0] val_waddr;

  smx_ram #(.W(W), .DEPTH(smx_pkg::STACK_DEPTH), .AW(smx_pkg::STK_AW)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(res),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  smx_ram #(.W(W), .DEPTH(smx_pkg::VAR_ENTRIES), .AW(smx_pkg::VAR_AW)) u_keys (
    .clk(clk), .we(cmd.new_var), .waddr(smx_pkg::VAR_AW'(vcnt_r)), .wdata(a_r),
    .raddr(idx_r), .rdata(key_rdata)
  );

  smx_ram #(.W(W), .DEPTH(smx_pkg::VAR_ENTRIES), .AW(smx_pkg::VAR_AW)) u_vals (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(top_r),
    .raddr(idx_r), .rdata(val_rdata)
  );

  // The entry below the top is read continuously; the controller captures it in S_LOAD.
  assign stk_raddr = smx_pkg::STK_AW'(cnt_r - smx_pkg::SP_W'(2));
  assign val_we    = cmd.val_wr | cmd.new_var;
  assign val_waddr = cmd.new_var ? smx_pkg::VAR_AW'(vcnt_r) : idx_r;
  assign key       = (op_r == smx_pkg::OP_ASSIGN) ? a_r : opnd_r;

  // Two-input ALU: a is the entry below the top, the top is the second operand.
  always_comb begin
    case (op_r)
      smx_pkg::OP_ADD: alu_res = a_r + top_r;
      smx_pkg::OP_SUB: alu_res = a_r - top_r;
      smx_pkg::OP_LT:  alu_res = W'($signed(a_r) < $signed(top_r));
      smx_pkg::OP_GT:  alu_res = W'($signed(a_r) > $signed(top_r));
      smx_pkg::OP_LE:  alu_res = W'($signed(a_r) <= $signed(top_r));
      smx_pkg::OP_GE:  alu_res = W'($signed(a_r) >= $signed(top_r));
      smx_pkg::OP_NE:  alu_res = W'(a_r != top_r);
      smx_pkg::OP_EQ:  alu_res = W'(a_r == top_r);
      smx_pkg::OP_AND: alu_res = W'((a_r != '0) && (top_r != '0));
      smx_pkg::OP_OR:  alu_res = W'((a_r != '0) || (top_r != '0));
      default:         alu_res = '0;
    endcase
  end

  assign mul_x = cmd.mul_base ? base_r : acc_r;
  assign prod  = mul_x * base_r;

  assign abs_a   = a_r[W-1] ? (W'(0) - a_r) : a_r;
  assign abs_b   = top_r[W-1] ? (W'(0) - top_r) : top_r;
  assign rem_sh  = {rem_r, quot_r[W-1]};
  assign diff    = rem_sh - {1'b0, dvs_r};
  assign div_res = qneg_r ? (W'(0) - quot_r) : quot_r;

  always_comb begin
    case (cmd.res_sel)
      smx_pkg::RS_ALU:    res = alu_res;
      smx_pkg::RS_ACC:    res = acc_r;
      smx_pkg::RS_DIV:    res = div_res;
      smx_pkg::RS_TOP:    res = top_r;
      smx_pkg::RS_NEGTOP: res = W'(0) - top_r;
      smx_pkg::RS_OPND:   res = opnd_r;
      smx_pkg::RS_VAR:    res = val_rdata;
      default:            res = '0;
    endcase
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    top_nxt   = top_r;
    stk_we    = 1'b0;
    stk_waddr = smx_pkg::STK_AW'(cnt_r);
    if (cmd.done) begin
      case (cmd.commit)
        smx_pkg::C_POP: begin
          cnt_nxt = cnt_r - smx_pkg::SP_W'(1);
          top_nxt = (cnt_r > smx_pkg::SP_W'(1)) ? a_r : '0;
        end
        smx_pkg::C_REPL1: begin
          top_nxt   = res;
          stk_we    = 1'b1;
          stk_waddr = smx_pkg::STK_AW'(cnt_r - smx_pkg::SP_W'(1));
        end
        smx_pkg::C_REPL2: begin
          cnt_nxt   = cnt_r - smx_pkg::SP_W'(1);
          top_nxt   = res;
          stk_we    = 1'b1;
          stk_waddr = smx_pkg::STK_AW'(cnt_r - smx_pkg::SP_W'(2));
        end
        smx_pkg::C_PUSH: begin
          cnt_nxt = cnt_r + smx_pkg::SP_W'(1);
          top_nxt = res;
          stk_we  = 1'b1;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      top_r       <= '0;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      top_r <= top_nxt;
      if (cmd.new_var) begin
        vcnt_r <= vcnt_r + smx_pkg::VC_W'(1);
      end
      if (cmd.done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_tuser[smx_pkg::OP_W-1:0];
      opnd_r <= in_tdata[W-1:0];
    end
    if (cmd.cap_a) begin
      a_r <= stk_rdata;
    end
    if (cmd.scan_init) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + smx_pkg::VAR_AW'(1);
    end
    if (cmd.mul_init) begin
      acc_r  <= a_r;
      base_r <= top_r;
    end else if (cmd.pow_init) begin
      acc_r  <= W'(1);
      base_r <= a_r;
      exp_r  <= top_r[W-1] ? '0 : top_r;
    end else if (cmd.mul_acc) begin
      acc_r <= prod;
    end else if (cmd.mul_base) begin
      base_r <= prod;
      exp_r  <= exp_r >> 1;
    end
    if (cmd.div_init) begin
      rem_r  <= '0;
      quot_r <= abs_a;
      dvs_r  <= abs_b;
      qneg_r <= a_r[W-1] ^ top_r[W-1];
      step_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
      quot_r <= {quot_r[W-2:0], ~diff[W]};
      step_r <= step_r + smx_pkg::STEP_W'(1);
    end
    if (cmd.done) begin
      out_data_r <= {
        5'd0,
        smx_pkg::DEPTH_W'(cnt_nxt),
        top_nxt,
        (cnt_nxt != '0),
        (cmd.jump ? opnd_r : W'(0)),
        cmd.jump,
        cmd.fault
      };
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    sts.op        = op_r;
    sts.out_free  = !out_valid_r || out_tready;
    sts.cnt_lt2   = cnt_r < smx_pkg::SP_W'(2);
    sts.cnt_zero  = cnt_r == '0;
    sts.cnt_full  = cnt_r == smx_pkg::SP_W'(smx_pkg::STACK_DEPTH);
    sts.top_zero  = top_r == '0;
    sts.exp_zero  = exp_r == '0;
    sts.exp_lsb   = exp_r[0];
    sts.div_last  = step_r == smx_pkg::STEP_W'(W - 1);
    sts.vcnt_zero = vcnt_r == '0;
    sts.vfull     = vcnt_r == smx_pkg::VC_W'(smx_pkg::VAR_ENTRIES);
    sts.key_hit   = key_rdata == key;
    sts.scan_last = (smx_pkg::VC_W'(idx_r) + smx_pkg::VC_W'(1)) == vcnt_r;
  end

endmodule
`default_nettype wire

@@ src/smx_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer that steps each instruction through the datapath.
// ----------------------------------------------------------------------------
module smx_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire smx_pkg::sts_t sts,
  output smx_pkg::cmd_t      cmd
);

  smx_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smx_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.fault   = smx_pkg::FLT_OK;
    cmd.commit  = smx_pkg::C_NONE;
    cmd.res_sel = smx_pkg::RS_ALU;
    in_tready   = 1'b0;
    case (state_r)
      smx_pkg::S_IDLE: begin
        in_tready = sts.out_free;
        if (in_tvalid && sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = smx_pkg::S_DECODE;
        end
      end
      smx_pkg::S_DECODE: begin
        state_nxt = smx_pkg::S_IDLE;
        case (sts.op)
          smx_pkg::OP_POP, smx_pkg::OP_BRZ: begin
            if (sts.cnt_zero) begin
              cmd.done  = 1'b1;
              cmd.fault = smx_pkg::FLT_UNDERFLOW;
            end else begin
              state_nxt = smx_pkg::S_LOAD;
            end
          end
          smx_pkg::OP_NEG: begin
            cmd.done = 1'b1;
            if (sts.cnt_zero) begin
              cmd.fault = smx_pkg::FLT_UNDERFLOW;
            end else begin
              cmd.commit  = smx_pkg::C_REPL1;
              cmd.res_sel = smx_pkg::RS_NEGTOP;
            end
          end
          smx_pkg::OP_JMP: begin
            cmd.done = 1'b1;
            cmd.jump = 1'b1;
          end
          smx_pkg::OP_PUSHIMM: begin
            cmd.done = 1'b1;
            if (sts.cnt_full) begin
              cmd.fault = smx_pkg::FLT_OVERFLOW;
            end else begin
              cmd.commit  = smx_pkg::C_PUSH;
              cmd.res_sel = smx_pkg::RS_OPND;
            end
          end
          smx_pkg::OP_PUSHVAR: begin
            if (sts.vcnt_zero) begin
              cmd.done  = 1'b1;
              cmd.fault = smx_pkg::FLT_MISSING;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = smx_pkg::S_SCAN_RD;
            end
          end
          smx_pkg::OP_POW, smx_pkg::OP_MUL, smx_pkg::OP_DIV, smx_pkg::OP_ADD,
          smx_pkg::OP_SUB, smx_pkg::OP_LT, smx_pkg::OP_GT, smx_pkg::OP_LE,
          smx_pkg::OP_GE, smx_pkg::OP_NE, smx_pkg::OP_EQ, smx_pkg::OP_AND,
          smx_pkg::OP_OR, smx_pkg::OP_ASSIGN: begin
            if (sts.cnt_lt2) begin
              cmd.done  = 1'b1;
              cmd.fault = smx_pkg::FLT_UNDERFLOW;
            end else begin
              state_nxt = smx_pkg::S_LOAD;
            end
          end
          default: begin
            cmd.done = 1'b1;
          end
        endcase
      end
      smx_pkg::S_LOAD: begin
        cmd.cap_a = 1'b1;
        state_nxt = smx_pkg::S_EXEC;
      end
      smx_pkg::S_EXEC: begin
        state_nxt = smx_pkg::S_IDLE;
        case (sts.op)
          smx_pkg::OP_POP: begin
            cmd.done   = 1'b1;
            cmd.commit = smx_pkg::C_POP;
          end
          smx_pkg::OP_BRZ: begin
            cmd.done   = 1'b1;
            cmd.commit = smx_pkg::C_POP;
            cmd.jump   = sts.top_zero;
          end
          smx_pkg::OP_MUL: begin
            cmd.mul_init = 1'b1;
            state_nxt    = smx_pkg::S_MUL;
          end
          smx_pkg::OP_POW: begin
            cmd.pow_init = 1'b1;
            state_nxt    = smx_pkg::S_POW_A;
          end
          smx_pkg::OP_DIV: begin
            if (sts.top_zero) begin
              cmd.done  = 1'b1;
              cmd.fault = smx_pkg::FLT_DIV_ZERO;
            end else begin
              cmd.div_init = 1'b1;
              state_nxt    = smx_pkg::S_DIV;
            end
          end
          smx_pkg::OP_ASSIGN: begin
            if (sts.vcnt_zero) begin
              cmd.new_var = 1'b1;
              cmd.done    = 1'b1;
              cmd.commit  = smx_pkg::C_REPL2;
              cmd.res_sel = smx_pkg::RS_TOP;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = smx_pkg::S_SCAN_RD;
            end
          end
          default: begin
            cmd.done   = 1'b1;
            cmd.commit = smx_pkg::C_REPL2;
          end
        endcase
      end
      smx_pkg::S_MUL: begin
        cmd.mul_acc = 1'b1;
        state_nxt   = smx_pkg::S_FIN_ACC;
      end
      smx_pkg::S_FIN_ACC: begin
        cmd.done    = 1'b1;
        cmd.commit  = smx_pkg::C_REPL2;
        cmd.res_sel = smx_pkg::RS_ACC;
        state_nxt   = smx_pkg::S_IDLE;
      end
      smx_pkg::S_POW_A: begin
        if (sts.exp_zero) begin
          cmd.done    = 1'b1;
          cmd.commit  = smx_pkg::C_REPL2;
          cmd.res_sel = smx_pkg::RS_ACC;
          state_nxt   = smx_pkg::S_IDLE;
        end else begin
          cmd.mul_acc = sts.exp_lsb;
          state_nxt   = smx_pkg::S_POW_B;
        end
      end
      smx_pkg::S_POW_B: begin
        cmd.mul_base = 1'b1;
        state_nxt    = smx_pkg::S_POW_A;
      end
      smx_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = smx_pkg::S_FIN_DIV;
        end
      end
      smx_pkg::S_FIN_DIV: begin
        cmd.done    = 1'b1;
        cmd.commit  = smx_pkg::C_REPL2;
        cmd.res_sel = smx_pkg::RS_DIV;
        state_nxt   = smx_pkg::S_IDLE;
      end
      smx_pkg::S_SCAN_RD: begin
        state_nxt = smx_pkg::S_SCAN_CMP;
      end
      smx_pkg::S_SCAN_CMP: begin
        state_nxt = smx_pkg::S_IDLE;
        if (sts.key_hit) begin
          cmd.done = 1'b1;
          if (sts.op == smx_pkg::OP_ASSIGN) begin
            cmd.val_wr  = 1'b1;
            cmd.commit  = smx_pkg::C_REPL2;
            cmd.res_sel = smx_pkg::RS_TOP;
          end else if (sts.cnt_full) begin
            cmd.fault = smx_pkg::FLT_OVERFLOW;
          end else begin
            cmd.commit  = smx_pkg::C_PUSH;
            cmd.res_sel = smx_pkg::RS_VAR;
          end
        end else if (sts.scan_last) begin
          cmd.done = 1'b1;
          if (sts.op != smx_pkg::OP_ASSIGN) begin
            cmd.fault = smx_pkg::FLT_MISSING;
          end else if (sts.vfull) begin
            cmd.fault = smx_pkg::FLT_STORE_FULL;
          end else begin
            cmd.new_var = 1'b1;
            cmd.commit  = smx_pkg::C_REPL2;
            cmd.res_sel = smx_pkg::RS_TOP;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = smx_pkg::S_SCAN_RD;
        end
      end
      default: begin
        state_nxt = smx_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/stack_machine_executor_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// Executes one pre-decoded stack-machine instruction per input transfer.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Contents
// in_      in   tuser: op [4:0]; tdata: operand [31:0]
// out_     out  tdata: fault, jump_taken, jump_target, top_valid, top_value,
//               depth (low bits first, zero padded to 80 bits)
//
// One instruction is in flight at a time, stepped by smx_ctrl. Push, negate,
// jump and faults found at decode finish in S_DECODE; pop, branch and
// two-operand ALU ops go on through S_LOAD and S_EXEC; multiply adds S_MUL
// and S_FIN_ACC, divide loops in S_DIV per quotient bit, and power loops in
// S_POW_A/S_POW_B per exponent bit. A variable lookup scans one key at a time.
// Reset is synchronous and clears the stack and variable counts at once;
// the memories need no clearing pass since only written entries are read.
// A new transfer is taken as soon as the output register is free or is
// being drained in the same cycle, so a stalled result delays the next one.
module stack_machine_executor_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [31:0] operand
  input  wire logic [smx_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [4:0] op, [7:5] zero
  input  wire logic [smx_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [2:0] fault, [3] jump_taken, [35:4] jump_target, [36] top_valid,
  // [68:37] top_value, [74:69] depth, [79:75] zero
  output logic [smx_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  smx_pkg::cmd_t cmd;
  smx_pkg::sts_t sts;

  // The controller only sequences; all data state and arithmetic live in smx_dp.
  smx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  smx_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // A new instruction is never taken while an unread result would be lost.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!out_tvalid || out_tready))
    else $error("input accepted while result pending");

  // The reported depth never exceeds the stack size.
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[74:69] <= 6'(smx_pkg::STACK_DEPTH)))
    else $error("depth out of range");

  // top_valid agrees with a nonzero depth.
  a_top_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[36] == (out_tdata[74:69] != 6'd0)))
    else $error("top_valid disagrees with depth");

  // No jump target is reported unless a jump is taken.
  a_jump_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[3]) |-> (out_tdata[35:4] == 32'd0))
    else $error("jump target without jump");

endmodule
`default_nettype wire
